>>> sv/clock_calendar_with_button_setting_assert.svh
// assertion macros for the clock calendar block
`ifndef CLOCK_CALENDAR_WITH_BUTTON_SETTING_ASSERT_SVH
`define CLOCK_CALENDAR_WITH_BUTTON_SETTING_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CCBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CCBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ccbs_pkg.sv
// shared constants, types and helper functions for the clock calendar block
`timescale 1ns / 1ps
`default_nettype none

package ccbs_pkg;

  // input kinds carried in tuser
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_KEYS = 1'b1;

  // configuration register indexes
  localparam logic CFG_TICKS_PER_SECOND = 1'b0;
  localparam logic CFG_DAYS_IN_MONTH    = 1'b1;

  // edit field codes
  localparam logic [1:0] EDIT_NONE = 2'd0;
  localparam logic [1:0] EDIT_HIGH = 2'd1;  // hour / year
  localparam logic [1:0] EDIT_MID  = 2'd2;  // minute / month
  localparam logic [1:0] EDIT_LOW  = 2'd3;  // second / day

  // single new press patterns
  localparam logic [3:0] RISE_SET  = 4'b0001;
  localparam logic [3:0] RISE_UP   = 4'b0010;
  localparam logic [3:0] RISE_DOWN = 4'b0100;
  localparam logic [3:0] RISE_VIEW = 4'b1000;

  localparam logic [7:0] SEG_DASH = 8'h40;

  localparam int OUT_TDATA_W = 104;
  localparam int IN_TDATA_W  = 8;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } digit_pair_t;

  // split a value below 128 into tens (mod 10) and ones; v*205>>11 equals v/10 here
  function automatic digit_pair_t split_digits(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  q10;
    digit_pair_t r;
    prod   = 15'(v) * 15'd205;
    q      = prod[14:11];
    q10    = 7'(q) * 7'd10;
    r.ones = 4'(v - q10);
    r.tens = (q >= 4'd10) ? q - 4'd10 : q;
    return r;
  endfunction

  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // tens byte low, ones byte high
  function automatic logic [15:0] pair_bytes(input logic [6:0] v);
    digit_pair_t d;
    d = split_digits(v);
    return {seg_digit(d.ones), seg_digit(d.tens)};
  endfunction

  // wrapping step in lo..hi; up from >=hi gives lo, down from <=lo or >hi gives hi
  function automatic logic [6:0] step_value(input logic [6:0] v, input logic [6:0] lo,
                                            input logic [6:0] hi, input logic up);
    logic [6:0] r;
    if (up) begin
      r = (v >= hi) ? lo : v + 7'd1;
    end else begin
      r = (v <= lo || v > hi) ? hi : v - 7'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/clock_calendar_with_button_setting.sv
// clock calendar with key setting and seven-segment output bytes
// the result of an accepted input transaction is registered and shows on the master side in the next cycle
// throughput: one transaction per cycle while the result is not stalled; the whole update of counters,
//   keys and display bytes settles between the state registers and the result register
// reset: synchronous active-high rst sets 23:59:55, day 29, month 12, year 99, view time,
//   no edit field, tick count 0, ticks_per_second 20, days_in_month 30; result invalid
`timescale 1ns / 1ps
`default_nettype none
`include "clock_calendar_with_button_setting_assert.svh"

module clock_calendar_with_button_setting
  import ccbs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [5:0]             cfg_data,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // keys[3:0], zero pad [7:4]
  input  wire logic                   s_axis_tuser,   // func[0]
  // result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // hour[4:0] minute[10:5] second[16:11] year[23:17] month[27:24] day_of_month[32:28]
  // edit_field[34:33] show_date[35] blink_off[36] segments[100:37], zero pad [103:101]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  // configuration registers
  logic [5:0] ticks_per_second;
  logic [4:0] days_in_month;

  // clock state
  logic [5:0] tick_count, tick_count_next;
  logic [5:0] second_reg, second_reg_next;
  logic [5:0] minute_reg, minute_reg_next;
  logic [4:0] hour_reg, hour_reg_next;
  logic [4:0] day_reg, day_reg_next;
  logic [3:0] month_reg, month_reg_next;
  logic [6:0] year_reg, year_reg_next;
  logic [3:0] last_pressed, last_pressed_next;
  logic [1:0] edit_sel, edit_sel_next;
  logic       date_view, date_view_next;
  logic       blink_phase, blink_phase_next;

  // datapath temporaries
  logic                   in_fire;
  logic                   func;
  logic [3:0]             keys_now;
  logic [3:0]             rise;
  logic [4:0]             month_len;
  logic [5:0]             sec_inc;
  logic [5:0]             day_inc;
  logic [3:0]             month_inc;
  logic [6:0]             year_inc;
  logic                   step_up;
  digit_pair_t            tick_digits;
  logic [15:0]            pair_hi, pair_mid, pair_lo;
  logic [63:0]            segs;
  logic [OUT_TDATA_W-1:0] out_data_next;

  assign func          = s_axis_tuser;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // the result register frees up in the same cycle it is taken
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;

  // a zero month length counts as one day
  assign month_len = (days_in_month == 5'd0) ? 5'd1 : days_in_month;

  // keys are active low; rising press edges against the last key sample
  assign keys_now = ~s_axis_tdata[3:0];
  assign rise     = keys_now & ~last_pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= 6'd20;
      days_in_month    <= 5'd30;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
        CFG_DAYS_IN_MONTH:    days_in_month    <= cfg_data[4:0];
        default:              ;
      endcase
    end
  end

  // next state for one transaction
  always_comb begin
    tick_count_next   = tick_count;
    second_reg_next   = second_reg;
    minute_reg_next   = minute_reg;
    hour_reg_next     = hour_reg;
    day_reg_next      = day_reg;
    month_reg_next    = month_reg;
    year_reg_next     = year_reg;
    last_pressed_next = last_pressed;
    edit_sel_next     = edit_sel;
    date_view_next    = date_view;
    blink_phase_next  = blink_phase;
    tick_digits       = '0;
    sec_inc           = second_reg + ((edit_sel == EDIT_NONE) ? 6'd1 : 6'd0);
    day_inc           = {1'b0, day_reg} + 6'd1;
    month_inc         = month_reg + 4'd1;
    year_inc          = year_reg + 7'd1;
    step_up           = (rise == RISE_UP);

    if (func == FUNC_TICK) begin
      tick_count_next  = tick_count + 6'd1;
      // blank half of the blink: tick count mod 10 at or above 5
      tick_digits      = split_digits({1'b0, tick_count_next});
      blink_phase_next = (tick_digits.ones >= 4'd5);
      if (tick_count_next >= ticks_per_second) begin
        tick_count_next = 6'd0;
        // seconds hold while a field is being edited
        if (sec_inc >= 6'd60) begin
          second_reg_next = 6'd0;
          if (minute_reg >= 6'd59) begin
            minute_reg_next = 6'd0;
            if (hour_reg >= 5'd23) begin
              hour_reg_next = 5'd0;
              if (day_inc > {1'b0, month_len}) begin
                day_reg_next = 5'd1;
                if (month_inc > 4'd12) begin
                  month_reg_next = 4'd1;
                  year_reg_next  = (year_inc >= 7'd100) ? 7'd0 : year_inc;
                end else begin
                  month_reg_next = month_inc;
                end
              end else begin
                day_reg_next = day_inc[4:0];
              end
            end else begin
              hour_reg_next = hour_reg + 5'd1;
            end
          end else begin
            minute_reg_next = minute_reg + 6'd1;
          end
        end else begin
          second_reg_next = sec_inc;
        end
      end
    end else begin
      last_pressed_next = keys_now;
      // several new presses at once do nothing
      case (rise)
        RISE_SET:  edit_sel_next  = edit_sel + 2'd1;
        RISE_VIEW: date_view_next = !date_view;
        RISE_UP, RISE_DOWN: begin
          case (edit_sel)
            EDIT_HIGH: begin
              if (date_view) begin
                year_reg_next = step_value(year_reg, 7'd0, 7'd99, step_up);
              end else begin
                hour_reg_next = 5'(step_value({2'b0, hour_reg}, 7'd0, 7'd23, step_up));
              end
            end
            EDIT_MID: begin
              if (date_view) begin
                month_reg_next = 4'(step_value({3'b0, month_reg}, 7'd1, 7'd12, step_up));
              end else begin
                minute_reg_next = 6'(step_value({1'b0, minute_reg}, 7'd0, 7'd59, step_up));
              end
            end
            EDIT_LOW: begin
              if (date_view) begin
                day_reg_next = 5'(step_value({2'b0, day_reg}, 7'd1, {2'b0, month_len},
                                             step_up));
              end else begin
                second_reg_next = 6'(step_value({1'b0, second_reg}, 7'd0, 7'd59, step_up));
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // display bytes from the updated state
  always_comb begin
    pair_hi  = pair_bytes(date_view_next ? year_reg_next : {2'b0, hour_reg_next});
    pair_mid = pair_bytes(date_view_next ? {3'b0, month_reg_next} : {1'b0, minute_reg_next});
    pair_lo  = pair_bytes(date_view_next ? {2'b0, day_reg_next} : {1'b0, second_reg_next});
    // the edited pair goes dark in the blank half of the blink
    if (blink_phase_next) begin
      case (edit_sel_next)
        EDIT_HIGH: pair_hi  = 16'h0000;
        EDIT_MID:  pair_mid = 16'h0000;
        EDIT_LOW:  pair_lo  = 16'h0000;
        default:   ;
      endcase
    end
    segs = {pair_lo, SEG_DASH, pair_mid, SEG_DASH, pair_hi};
    out_data_next = {3'b000, segs, blink_phase_next, date_view_next, edit_sel_next,
                     day_reg_next, month_reg_next, year_reg_next, second_reg_next,
                     minute_reg_next, hour_reg_next};
  end

  // state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= 6'd0;
      second_reg   <= 6'd55;
      minute_reg   <= 6'd59;
      hour_reg     <= 5'd23;
      day_reg      <= 5'd29;
      month_reg    <= 4'd12;
      year_reg     <= 7'd99;
      last_pressed <= 4'd0;
      edit_sel     <= EDIT_NONE;
      date_view    <= 1'b0;
      blink_phase  <= 1'b0;
    end else if (in_fire) begin
      tick_count   <= tick_count_next;
      second_reg   <= second_reg_next;
      minute_reg   <= minute_reg_next;
      hour_reg     <= hour_reg_next;
      day_reg      <= day_reg_next;
      month_reg    <= month_reg_next;
      year_reg     <= year_reg_next;
      last_pressed <= last_pressed_next;
      edit_sel     <= edit_sel_next;
      date_view    <= date_view_next;
      blink_phase  <= blink_phase_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= out_data_next;
    end
  end

  // every accepted transaction leaves a result behind
  `CCBS_ASSERT_NEXT(a_result_follows, clk, rst, in_fire, m_axis_tvalid, "no result after accept")
  // a held result blocks new input
  `CCBS_ASSERT_NOW(a_stall_blocks, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
                   "input taken over a stalled result")
  // seconds freeze while a field is being edited
  `CCBS_ASSERT_NEXT(a_edit_freeze, clk, rst,
                    in_fire && func == FUNC_TICK && edit_sel != EDIT_NONE,
                    second_reg == $past(second_reg), "seconds moved during edit")
  // key samples never touch the tick counter
  `CCBS_ASSERT_NEXT(a_keys_keep_tick, clk, rst, in_fire && func == FUNC_KEYS,
                    tick_count == $past(tick_count), "tick count moved on key sample")

endmodule

`default_nettype wire
